// ===== src/ham_pkg.sv =====
package ham_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_BITS       = 63;
  localparam int SYN_BITS      = 6;
  localparam int CFG_W         = 6;
  localparam int PCNT_W        = 3;

  localparam logic [CFG_W-1:0] RST_DATA_BITS = CFG_W'(4);

  localparam logic ACTION_ENCODE = 1'b0;
  localparam logic ACTION_CHECK  = 1'b1;

  typedef logic [MAX_DATA_BITS-1:0] data_t;
  typedef logic [CW_BITS-1:0]       cw_t;
  typedef logic [SYN_BITS-1:0]      syn_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  // Out-of-range lengths: 0 acts as 1, anything above the maximum saturates.
  function automatic cfg_t clamp_m(input cfg_t v);
    cfg_t res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DATA_BITS)) begin
      res = CFG_W'(MAX_DATA_BITS);
    end
    return res;
  endfunction

  // Smallest p with 2^p >= m + p + 1; never more than seven steps.
  function automatic logic [PCNT_W-1:0] parity_count(input cfg_t m);
    logic [PCNT_W-1:0] p;
    p = '0;
    for (int i = 0; i < 7; i++) begin
      if ((8'd1 << p) < (8'(p) + 8'(m) + 8'd1)) begin
        p = p + PCNT_W'(1);
      end
    end
    return p;
  endfunction

  function automatic data_t data_mask(input cfg_t v);
    cfg_t m;
    m = clamp_m(v);
    return data_t'((64'd1 << m) - 64'd1);
  endfunction

  function automatic cw_t cw_mask(input cfg_t v);
    cfg_t m;
    cfg_t n;
    m = clamp_m(v);
    n = m + CFG_W'(parity_count(m));
    return cw_t'((64'd1 << n) - 64'd1);
  endfunction

  // Positions (1-based) whose index has bit x set.
  function automatic cw_t group_mask(input int x);
    cw_t mask;
    mask = '0;
    for (int pos = 1; pos <= CW_BITS; pos++) begin
      if (((pos >> x) & 1) != 0) begin
        mask = mask | (cw_t'(1) << (pos - 1));
      end
    end
    return mask;
  endfunction

endpackage

// ===== src/ham_if.sv =====
interface ham_in_if;
  logic                  valid;
  logic                  ready;
  logic                  action;
  ham_pkg::data_t        data_word;
  ham_pkg::cw_t          received_word;

  modport source (output valid, action, data_word, received_word, input ready);
  modport sink   (input valid, action, data_word, received_word, output ready);
endinterface

interface ham_out_if;
  logic                  valid;
  logic                  ready;
  ham_pkg::cw_t          codeword;
  logic                  error_found;
  ham_pkg::syn_t         error_position;

  modport source (output valid, codeword, error_found, error_position, input ready);
  modport sink   (input valid, codeword, error_found, error_position, output ready);
endinterface

interface ham_cfg_if;
  logic                  valid;
  logic                  ready;
  ham_pkg::cfg_t         data_bits;

  modport source (output valid, data_bits, input ready);
  modport sink   (input valid, data_bits, output ready);
endinterface

// ===== src/hamming_encode_and_syndrome_top.sv =====
// Channel  | Dir | Handshake    | Payload
// in_i     | in  | valid/ready  | action, data_word, received_word
// res_o    | out | valid/ready  | codeword, error_found, error_position
// cfg_i    | in  | valid/ready  | data_bits (always ready)
//
// One word per cycle while the result channel is not stalled.
// Input register masks unused bits, then the parity trees feed the result register.
// A stalled result register holds its word while the input register can still fill.
// rst_ni clears both valid flags and sets data_bits to 4 (masks for m = 4, n = 7).
module hamming_encode_and_syndrome_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  ham_in_if.sink          in_i,
  ham_out_if.source       res_o,
  ham_cfg_if.sink         cfg_i
);

  // Masks are derived at write time so a transfer right after a write sees them.
  ham_pkg::data_t dmask_q;
  ham_pkg::cw_t   rmask_q;

  logic           s1_v_q;
  logic           s1_act_q;
  ham_pkg::data_t s1_data_q;
  ham_pkg::cw_t   s1_rcv_q;
  logic           s1_rdy;

  logic           s2_v_q;
  ham_pkg::cw_t   cw_q;
  logic           ef_q;
  ham_pkg::syn_t  ep_q;
  logic           s2_rdy;

  ham_pkg::cw_t   spread;
  ham_pkg::cw_t   par_place;
  ham_pkg::cw_t   word;
  ham_pkg::syn_t  syn;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmask_q <= ham_pkg::data_mask(ham_pkg::RST_DATA_BITS);
      rmask_q <= ham_pkg::cw_mask(ham_pkg::RST_DATA_BITS);
    end else if (cfg_i.valid) begin
      dmask_q <= ham_pkg::data_mask(cfg_i.data_bits);
      rmask_q <= ham_pkg::cw_mask(cfg_i.data_bits);
    end
  end

  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign s2_rdy     = !s2_v_q || res_o.ready;
  assign in_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_i.valid) begin
      s1_act_q  <= in_i.action;
      s1_data_q <= in_i.data_word & dmask_q;
      s1_rcv_q  <= in_i.received_word & rmask_q;
    end
  end

  // Data bits go to the non-power-of-two positions; parity slots take the syndrome.
  for (genvar pos = 1; pos <= ham_pkg::CW_BITS; pos++) begin : g_pos
    if ((pos & (pos - 1)) == 0) begin : g_par
      assign spread[pos-1]    = 1'b0;
      assign par_place[pos-1] = syn[$clog2(pos)];
    end else begin : g_dat
      localparam int DI = pos - 1 - $clog2(pos);
      assign spread[pos-1]    = s1_data_q[DI];
      assign par_place[pos-1] = 1'b0;
    end
  end

  assign word = (s1_act_q == ham_pkg::ACTION_CHECK) ? s1_rcv_q : spread;

  for (genvar x = 0; x < ham_pkg::SYN_BITS; x++) begin : g_syn
    localparam ham_pkg::cw_t GM = ham_pkg::group_mask(x);
    assign syn[x] = ^(word & GM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      if (s1_act_q == ham_pkg::ACTION_CHECK) begin
        cw_q <= '0;
        ef_q <= |syn;
        ep_q <= syn;
      end else begin
        cw_q <= spread | par_place;
        ef_q <= 1'b0;
        ep_q <= '0;
      end
    end
  end

  assign res_o.valid          = s2_v_q;
  assign res_o.codeword       = cw_q;
  assign res_o.error_found    = ef_q;
  assign res_o.error_position = ep_q;

endmodule

// ===== src/ham_chk.sv =====
module ham_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input ham_pkg::cw_t  codeword_i,
  input logic          error_found_i,
  input ham_pkg::syn_t error_position_i
);

  // Flag and syndrome must agree.
  a_flag_matches_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (error_found_i == (error_position_i != '0)))
    else $error("error_found disagrees with error_position");

  // A nonzero codeword only comes from encode, which reports no error.
  a_encode_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && (codeword_i != '0)) |-> (!error_found_i && (error_position_i == '0)))
    else $error("encode result carries an error report");

  // Result must hold while stalled.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=>
      (res_valid_i && $stable(codeword_i) && $stable(error_found_i)
       && $stable(error_position_i)))
    else $error("result changed while stalled");

  // A fresh result follows an input transfer, held first in the input register, then in the result register.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input transfer");

endmodule

bind hamming_encode_and_syndrome_top ham_chk u_ham_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .codeword_i       (res_o.codeword),
  .error_found_i    (res_o.error_found),
  .error_position_i (res_o.error_position)
);
